FILE: sv/encoder_speed_pi_smoothed_top_defines.svh
// assertion macros shared by the encoder speed pi controller rtl
// no dependencies; included by the files that carry assertions
`ifndef ENCODER_SPEED_PI_SMOOTHED_TOP_DEFINES_SVH
`define ENCODER_SPEED_PI_SMOOTHED_TOP_DEFINES_SVH

// same-cycle implication
`define ESPIS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("espis assertion failed");

// next-cycle implication
`define ESPIS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("espis assertion failed");

`endif

FILE: sv/espis_pkg.sv
// types, codes and saturation helper for the encoder speed pi controller
// no dependencies
package espis_pkg;

    localparam int WIDE_W = 66;
    localparam int OP_W   = 33;
    localparam int DIV_W  = 40;
    localparam int CNT_W  = $clog2(DIV_W);

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [OP_W-1:0]   t_op;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [2:0] {
        REG_SPEED_OFFSET     = 3'd0,
        REG_SPEED_SCALE      = 3'd1,
        REG_VELOCITY_SCALE   = 3'd2,
        REG_GAIN_P           = 3'd3,
        REG_GAIN_I           = 3'd4,
        REG_SMOOTHING_PERIOD = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic               operation;
        logic [15:0]        left_counter;
        logic [15:0]        right_counter;
        logic signed [31:0] extra_setpoint;
        logic signed [31:0] velocity_cmd;
        logic [5:0]         phase_index;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] measured_speed;
        logic signed [31:0] control_output;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  reg_index;
        logic [31:0] reg_data;
    } t_cfg_word;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [5:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat;

    localparam t_wide SAT_MAX = t_wide'(64'sd2147483647);
    localparam t_wide SAT_MIN = t_wide'(-64'sd2147483648);

    function automatic t_sat sat32(input t_wide x);
        t_sat r;
        if (x > SAT_MAX) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end else begin
            r.clip = 1'b0;
            r.val  = x[31:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/espis_chan_if.sv
// valid/ready channel carrying one word of a given payload type
// payload types come from espis_pkg at the place of instantiation
interface espis_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/espis_mul.sv
// shared signed 33x33 multiplier with registered product
// depends on espis_pkg
module espis_mul import espis_pkg::*; (
    input  logic  i_clk,
    input  t_op   i_a,
    input  t_op   i_b,
    output t_wide o_p
);
    t_wide r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

FILE: sv/espis_div.sv
// restoring divider, one quotient bit per cycle, unsigned dividend by 6-bit divisor
// depends on espis_pkg and the assertion macro header
`include "encoder_speed_pi_smoothed_top_defines.svh"

module espis_div import espis_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [5:0]       r_rem;
    logic [5:0]       r_divisor;
    logic [DIV_W-1:0] r_q;

    logic [6:0] w_cand;
    logic       w_ge;

    always_comb begin
        w_cand = {r_rem, r_q[DIV_W-1]};
        w_ge   = (w_cand >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == CNT_LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
            r_q       <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? 6'(w_cand - {1'b0, r_divisor}) : w_cand[5:0];
            r_q   <= {r_q[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    `ESPIS_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_req.start, !r_busy)
    `ESPIS_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy) && !r_busy)
endmodule

FILE: sv/encoder_speed_pi_smoothed_top.sv
// Encoder speed PI controller with interpolated output. A control update (operation 0)
// runs seven steps through one shared 33x33 multiplier (speed, velocity term,
// proportional and integral terms) under a small sequencer. A smoothing tick (operation 1)
// waits on the one-bit-per-cycle divider that divides the 40-bit scaled delta by the
// smoothing period. One item is worked on at a time; the input is ready again once its
// result sits in the output register.
// All values are signed fixed point with FRAC_BITS fraction bits and saturate to 32 bits.
// depends on espis_pkg, espis_chan_if, espis_mul, espis_div and the macro header
`include "encoder_speed_pi_smoothed_top_defines.svh"

module encoder_speed_pi_smoothed_top import espis_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    espis_chan_if.sink   i_cfg,
    espis_chan_if.sink   i_in,
    espis_chan_if.source o_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_T1, S_T2, S_TDIV, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic signed [31:0] r_speed_offset, r_speed_scale, r_velocity_scale, r_gain_p, r_gain_i;
    logic [5:0]         r_period;

    // controller state
    logic [15:0]        r_left_prev, r_right_prev;
    logic signed [31:0] r_integral, r_out_prev, r_out_latest, r_speed_hold;

    // work registers
    logic signed [31:0] r_half, r_goal, r_extra, r_speed, r_err, r_pterm, r_result;
    logic [6:0]         r_phase;
    logic               r_neg;
    logic               r_clip;

    // output register
    logic      r_out_valid;
    t_out_word r_out;

    t_op      w_a, w_b;
    t_wide    w_prod, w_mag, w_quo;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic [15:0]        w_rnow;
    logic signed [15:0] w_dl, w_dr;
    t_sat               w_half, w_rnd, w_err, w_integ, w_out, w_tick;
    logic               w_in_acc, w_out_load;

    function automatic t_wide round_shift(input t_wide p);
        t_wide bias;
        bias = t_wide'(1) <<< (FRAC_BITS - 1);
        return (p + bias) >>> FRAC_BITS;
    endfunction

    espis_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_prod)
    );

    espis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_cfg.ready   = i_rst_n;
    assign i_in.ready    = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            S_M1: begin
                w_a = t_op'(r_half);
                w_b = t_op'(r_speed_scale);
            end
            S_M2: begin
                w_a = t_op'(r_goal);
                w_b = t_op'(r_velocity_scale);
            end
            S_M4: begin
                w_a = t_op'(r_err);
                w_b = t_op'(r_gain_p);
            end
            S_M5: begin
                w_a = t_op'(r_err);
                w_b = t_op'(r_gain_i);
            end
            S_T1: begin
                w_a = t_op'(r_out_latest) - t_op'(r_out_prev);
                w_b = {{(OP_W-7){1'b0}}, r_phase};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        w_rnow  = 16'(-i_in.payload.right_counter);
        w_dl    = i_in.payload.left_counter - r_left_prev;
        w_dr    = w_rnow - r_right_prev;
        w_half  = sat32((t_wide'(w_dl) + t_wide'(w_dr)) <<< (FRAC_BITS - 1));
        w_rnd   = sat32(round_shift(w_prod));
        w_err   = sat32(t_wide'(r_speed_offset) - t_wide'(r_speed) + t_wide'(r_extra)
                        + t_wide'(w_rnd.val));
        w_integ = sat32(t_wide'(r_integral) + t_wide'(w_rnd.val));
        w_out   = sat32(t_wide'(r_pterm) + t_wide'(r_integral));
        w_mag   = w_prod[WIDE_W-1] ? -w_prod : w_prod;
        w_quo   = t_wide'(w_div_rsp.quotient);
        w_tick  = sat32((r_neg ? -w_quo : w_quo) + t_wide'(r_out_prev));

        w_div_req.start    = (r_state == S_T2);
        w_div_req.dividend = w_mag[DIV_W-1:0];
        w_div_req.divisor  = (r_period == 6'd0) ? 6'd1 : r_period;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_offset   <= 32'sd0;
            r_speed_scale    <= 32'sd65536;
            r_velocity_scale <= 32'sd65536;
            r_gain_p         <= 32'sd19660800;
            r_gain_i         <= 32'sd6554;
            r_period         <= 6'd20;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.payload.reg_index))
                REG_SPEED_OFFSET:     r_speed_offset   <= i_cfg.payload.reg_data;
                REG_SPEED_SCALE:      r_speed_scale    <= i_cfg.payload.reg_data;
                REG_VELOCITY_SCALE:   r_velocity_scale <= i_cfg.payload.reg_data;
                REG_GAIN_P:           r_gain_p         <= i_cfg.payload.reg_data;
                REG_GAIN_I:           r_gain_i         <= i_cfg.payload.reg_data;
                REG_SMOOTHING_PERIOD: r_period         <= i_cfg.payload.reg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_left_prev  <= '0;
            r_right_prev <= '0;
            r_integral   <= '0;
            r_out_prev   <= '0;
            r_out_latest <= '0;
            r_speed_hold <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in.payload.operation == OP_UPDATE) begin
                            r_left_prev  <= i_in.payload.left_counter;
                            r_right_prev <= w_rnow;
                            r_state      <= S_M1;
                        end else begin
                            r_state <= S_T1;
                        end
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_M4;
                S_M4: r_state <= S_M5;
                S_M5: r_state <= S_M6;
                S_M6: begin
                    r_integral <= w_integ.val;
                    r_state    <= S_M7;
                end
                S_M7: begin
                    r_out_prev   <= r_out_latest;
                    r_out_latest <= w_out.val;
                    r_speed_hold <= r_speed;
                    r_state      <= S_DONE;
                end
                S_T1: r_state <= S_T2;
                S_T2: r_state <= S_TDIV;
                S_TDIV: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_half  <= w_half.val;
                r_clip  <= (i_in.payload.operation == OP_UPDATE) ? w_half.clip : 1'b0;
                r_goal  <= i_in.payload.velocity_cmd;
                r_extra <= i_in.payload.extra_setpoint;
                r_phase <= {1'b0, i_in.payload.phase_index} + 7'd1;
            end
            S_M2: begin
                r_speed <= w_rnd.val;
                r_clip  <= r_clip | w_rnd.clip;
            end
            S_M3: begin
                r_err  <= w_err.val;
                r_clip <= r_clip | w_rnd.clip | w_err.clip;
            end
            S_M5: begin
                r_pterm <= w_rnd.val;
                r_clip  <= r_clip | w_rnd.clip;
            end
            S_M6: r_clip <= r_clip | w_rnd.clip | w_integ.clip;
            S_M7: begin
                r_result <= w_out.val;
                r_clip   <= r_clip | w_out.clip;
            end
            S_T2: r_neg <= w_prod[WIDE_W-1];
            S_TDIV: begin
                if (w_div_rsp.done) begin
                    r_result <= w_tick.val;
                    r_clip   <= w_tick.clip;
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out.measured_speed <= r_speed_hold;
            r_out.control_output <= r_result;
            r_out.saturated      <= r_clip;
        end
    end

    `ESPIS_ASSERT_NXT(a_update_enters_mul, i_clk, i_rst_n,
        w_in_acc && (i_in.payload.operation == OP_UPDATE), r_state == S_M1)
    `ESPIS_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_rsp.done, r_state == S_TDIV)
    `ESPIS_ASSERT_NXT(a_load_sets_valid, i_clk, i_rst_n, w_out_load,
        r_out_valid && (r_state == S_IDLE))
endmodule
